>>> rtl/pgbc_pkg.sv
// Shared types and constants for the particle grid binning classifier.
// Holds command, kind and class codes, the cell record and queue entry layouts.
// No dependencies.
`default_nettype none

package pgbc_pkg;

	// Stream and field widths
	localparam int POS_W      = 20;
	localparam int DENS_W     = 16;
	localparam int COUNT_W    = 16;
	localparam int SUM_W      = 24;
	localparam int ECHO_W     = 5;
	localparam int GSIZE_W    = 6;
	localparam int G_W        = 7;
	localparam int IN_DATA_W  = 96;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

	// Configuration register indexes (byte address bit 2)
	localparam logic REG_GRID_SIZE  = 1'b0;
	localparam logic REG_FLUID_THR  = 1'b1;

	localparam logic [GSIZE_W-1:0] GRID_SIZE_RST = 6'd32;
	localparam logic [SUM_W-1:0]   FLUID_THR_RST = 24'd51;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_FLUID = 2'd0,
		KIND_WALL  = 2'd1,
		KIND_OTHER = 2'd2,
		KIND_SPARE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CLASS_AIR   = 2'd0,
		CLASS_FLUID = 2'd1,
		CLASS_WALL  = 2'd2,
		CLASS_SPARE = 2'd3
	} class_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_ACCESS,
		ST_CLEAR
	} back_state_t;

	// Aggregates stored for one cell
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               wall;
		logic               other;
		logic [SUM_W-1:0]   sum;
	} cell_rec_t;

	// Decoded item passed from front to back (cell address travels beside it)
	typedef struct packed {
		cmd_t              cmd;
		logic [ECHO_W-1:0] echo_x;
		logic [ECHO_W-1:0] echo_y;
		logic [ECHO_W-1:0] echo_z;
		kind_t             kind;
		logic [DENS_W-1:0] density;
		logic              out_of_range;
	} op_t;

	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		class_t             cls;
		logic [COUNT_W-1:0] count;
		logic [ECHO_W-1:0]  z;
		logic [ECHO_W-1:0]  y;
		logic [ECHO_W-1:0]  x;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/pgbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pgbc_ram #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 32768
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire                       re,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/pgbc_queue.sv
// Small flop-based FIFO between the front and the back.
// No dependencies.
`default_nettype none

module pgbc_queue #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire [WIDTH-1:0]  wdata,
	output logic             full,
	input  wire              pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/pgbc_front.sv
// Front end: accepts items, bins positions into cells, checks query range.
// Depends on pgbc_pkg; feeds pgbc_queue.
`default_nettype none

module pgbc_front #(
	parameter int MAX_GRID = 32,
	parameter int IDX_W    = 5
) (
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire [pgbc_pkg::IN_DATA_W-1:0]         s_tdata,
	input  wire [pgbc_pkg::IN_USER_W-1:0]         s_tuser,
	input  wire [pgbc_pkg::GSIZE_W-1:0]           grid_size,
	input  wire                                   init_busy,
	input  wire                                   q_full,
	output logic                                  q_push,
	output pgbc_pkg::op_t                         q_op,
	output logic [3*IDX_W-1:0]                    q_addr
);

	import pgbc_pkg::*;

	localparam logic [G_W-1:0] MAX_G = G_W'(MAX_GRID);

	logic [G_W-1:0]           g_eff;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [POS_W-1:0]  pos_z;
	logic [ECHO_W-1:0]        qry_x;
	logic [ECHO_W-1:0]        qry_y;
	logic [ECHO_W-1:0]        qry_z;
	logic [IDX_W-1:0]         bin_x;
	logic [IDX_W-1:0]         bin_y;
	logic [IDX_W-1:0]         bin_z;
	cmd_t                     cmd;

	// Scale by grid size, truncate, clamp to 0..g-1
	function automatic logic [IDX_W-1:0] bin_axis(input logic signed [POS_W-1:0] pos,
		input logic [G_W-1:0] g);
		logic signed [POS_W+G_W:0] prod;
		logic [10:0]               idx_raw;
		logic [10:0]               idx_max;
		logic [10:0]               idx;
		prod    = pos * $signed({1'b0, g});
		idx_raw = prod[POS_W+G_W-1:16];
		idx_max = 11'(g - 1'b1);
		if (prod[POS_W+G_W]) begin
			idx = '0;
		end else if (idx_raw > idx_max) begin
			idx = idx_max;
		end else begin
			idx = idx_raw;
		end
		return IDX_W'(idx);
	endfunction

	// Effective grid size: zero acts as one, cap at the built grid
	always_comb begin
		if (grid_size == '0) begin
			g_eff = G_W'(1);
		end else if ({1'b0, grid_size} > MAX_G) begin
			g_eff = MAX_G;
		end else begin
			g_eff = {1'b0, grid_size};
		end
	end

	// Unpack the item
	assign cmd   = cmd_t'(s_tuser[1:0]);
	assign pos_x = s_tdata[19:0];
	assign pos_y = s_tdata[39:20];
	assign pos_z = s_tdata[59:40];
	assign qry_x = s_tdata[82:78];
	assign qry_y = s_tdata[87:83];
	assign qry_z = s_tdata[92:88];

	assign bin_x = bin_axis(pos_x, g_eff);
	assign bin_y = bin_axis(pos_y, g_eff);
	assign bin_z = bin_axis(pos_z, g_eff);

	// Accept while the queue has room and the store is not being initialized
	assign s_tready = !q_full && !init_busy;
	assign q_push   = s_tvalid && s_tready;

	// Build the queue entry
	always_comb begin
		q_op.cmd          = cmd;
		q_op.kind         = kind_t'(s_tdata[61:60]);
		q_op.density      = s_tdata[77:62];
		q_op.out_of_range = 1'b0;
		q_op.echo_x       = '0;
		q_op.echo_y       = '0;
		q_op.echo_z       = '0;
		q_addr            = {bin_x, bin_y, bin_z};
		case (cmd)
			CMD_INSERT: begin
				q_op.echo_x = ECHO_W'(bin_x);
				q_op.echo_y = ECHO_W'(bin_y);
				q_op.echo_z = ECHO_W'(bin_z);
			end
			CMD_QUERY: begin
				q_op.echo_x       = qry_x;
				q_op.echo_y       = qry_y;
				q_op.echo_z       = qry_z;
				q_op.out_of_range = ({2'b0, qry_x} >= g_eff) || ({2'b0, qry_y} >= g_eff)
					|| ({2'b0, qry_z} >= g_eff);
				q_addr            = {IDX_W'(qry_x), IDX_W'(qry_y), IDX_W'(qry_z)};
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/pgbc_back.sv
// Back end: clears the cell store, runs insert read-modify-writes and queries.
// Depends on pgbc_pkg and pgbc_ram; drains pgbc_queue.
`default_nettype none

module pgbc_back #(
	parameter int ADDR_W = 15
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         q_empty,
	input  pgbc_pkg::op_t               q_op,
	input  wire [ADDR_W-1:0]            q_addr,
	output logic                        q_pop,
	input  wire [pgbc_pkg::SUM_W-1:0]   fluid_threshold,
	output logic                        init_busy,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output pgbc_pkg::result_t           m_result
);

	import pgbc_pkg::*;

	localparam int REC_W = $bits(cell_rec_t);

	back_state_t            state_q;
	back_state_t            state_d;
	logic [ADDR_W-1:0]      sweep_q;
	op_t                    op_q;
	logic [ADDR_W-1:0]      addr_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic                   slot_free;
	logic                   sweep_last;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	cell_rec_t              ram_wdata;
	logic [REC_W-1:0]       ram_rdata;
	cell_rec_t              rec;
	cell_rec_t              upd;
	logic [SUM_W:0]         sum_ext;
	logic                   result_load;
	result_t                result_d;
	logic                   sweep_adv;

	pgbc_ram #(
		.WIDTH (REC_W),
		.DEPTH (2 ** ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (q_pop),
		.raddr (q_addr),
		.rdata (ram_rdata)
	);

	assign rec        = cell_rec_t'(ram_rdata);
	assign slot_free  = !out_valid_q || m_tready;
	assign sweep_last = &sweep_q;
	assign init_busy  = (state_q == ST_INIT);
	assign m_tvalid   = out_valid_q;
	assign m_result   = out_q;

	// Update one cell's aggregates for an insert
	always_comb begin
		upd     = rec;
		sum_ext = {1'b0, rec.sum} + (SUM_W + 1)'(op_q.density);
		if (rec.count != COUNT_MAX) begin
			upd.count = rec.count + 1'b1;
		end
		case (op_q.kind)
			KIND_FLUID: upd.sum   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
			KIND_WALL:  upd.wall  = 1'b1;
			default:    upd.other = 1'b1;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (!q_empty) state_d = (q_op.cmd == CMD_CLEAR) ? ST_CLEAR : ST_ACCESS;
			end
			ST_ACCESS: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (sweep_last && slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_pop       = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = sweep_q;
		ram_wdata   = '0;
		result_load = 1'b0;
		sweep_adv   = 1'b0;
		result_d    = '0;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				sweep_adv = 1'b1;
			end
			ST_IDLE: begin
				q_pop = !q_empty;
			end
			ST_ACCESS: begin
				result_load = slot_free;
				ram_waddr   = addr_q;
				ram_wdata   = upd;
				case (op_q.cmd)
					CMD_INSERT: begin
						ram_we          = slot_free;
						result_d.x      = op_q.echo_x;
						result_d.y      = op_q.echo_y;
						result_d.z      = op_q.echo_z;
						result_d.count  = upd.count;
						result_d.sum    = upd.sum;
						if (upd.wall) begin
							result_d.cls = CLASS_WALL;
						end else if (!upd.other && (upd.sum > fluid_threshold)) begin
							result_d.cls = CLASS_FLUID;
						end else begin
							result_d.cls = CLASS_AIR;
						end
					end
					CMD_QUERY: begin
						result_d.x = op_q.echo_x;
						result_d.y = op_q.echo_y;
						result_d.z = op_q.echo_z;
						if (!op_q.out_of_range) begin
							result_d.count = rec.count;
							result_d.sum   = rec.sum;
							if (rec.wall) begin
								result_d.cls = CLASS_WALL;
							end else if (!rec.other && (rec.sum > fluid_threshold)) begin
								result_d.cls = CLASS_FLUID;
							end else begin
								result_d.cls = CLASS_AIR;
							end
						end
					end
					default: begin
					end
				endcase
			end
			ST_CLEAR: begin
				ram_we      = 1'b1;
				sweep_adv   = !(sweep_last && !slot_free);
				result_load = sweep_last && slot_free;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (sweep_adv) begin
				sweep_q <= sweep_q + 1'b1;
			end
		end
	end

	// Hold the item being worked on
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q   <= q_op;
			addr_q <= q_addr;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			out_q <= result_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/particle_grid_binning_classifier_unit.sv
// Particle grid binning classifier: bins particles into a cubic grid of cells
// and answers cell queries. Insert and query read the store; an insert then writes
// the updated cell, both load a result, and one item ends before the next is taken.
// Clear writes one cell per cycle (the last waits for a free output slot) over all
// MAX_GRID-rounded-up-to-power-of-2 cubed cells (32768 at MAX_GRID=32).
// After reset the same sweep runs with s_tready low.
`default_nettype none

module particle_grid_binning_classifier_unit #(
	parameter int MAX_GRID = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Input stream
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// pos_x[19:0], pos_y[39:20], pos_z[59:40], particle_kind[61:60],
	// particle_density[77:62], query_x[82:78], query_y[87:83], query_z[92:88]
	input  wire [pgbc_pkg::IN_DATA_W-1:0]       s_tdata,
	// command[1:0]
	input  wire [pgbc_pkg::IN_USER_W-1:0]       s_tuser,
	// Result stream
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// cell_x[4:0], cell_y[9:5], cell_z[14:10], particle_count[30:15],
	// cell_class[32:31], density_total[56:33]
	output logic [pgbc_pkg::OUT_DATA_W-1:0]     m_tdata,
	// Configuration port
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire [2:0]                           paddr,
	input  wire [31:0]                          pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	import pgbc_pkg::*;

	localparam int IDX_W  = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
	localparam int ADDR_W = 3 * IDX_W;
	localparam int OP_W   = $bits(op_t);

	logic [GSIZE_W-1:0]  grid_size_q;
	logic [SUM_W-1:0]    fluid_thr_q;
	logic                cfg_wr;

	logic                init_busy;
	logic                q_push;
	logic                q_pop;
	logic                q_full;
	logic                q_empty;
	op_t                 push_op;
	logic [ADDR_W-1:0]   push_addr;
	logic [OP_W+ADDR_W-1:0] pop_word;
	op_t                 pop_op;
	logic [ADDR_W-1:0]   pop_addr;
	result_t             result;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_SIZE_RST;
			fluid_thr_q <= FLUID_THR_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_GRID_SIZE: grid_size_q <= pwdata[GSIZE_W-1:0];
				REG_FLUID_THR: fluid_thr_q <= pwdata[SUM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GRID_SIZE: prdata = 32'(grid_size_q);
			REG_FLUID_THR: prdata = 32'(fluid_thr_q);
			default:       prdata = '0;
		endcase
	end

	pgbc_front #(
		.MAX_GRID (MAX_GRID),
		.IDX_W    (IDX_W)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.grid_size (grid_size_q),
		.init_busy (init_busy),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (push_op),
		.q_addr    (push_addr)
	);

	pgbc_queue #(
		.WIDTH (OP_W + ADDR_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({push_addr, push_op}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (pop_word),
		.empty  (q_empty)
	);

	assign pop_op   = op_t'(pop_word[OP_W-1:0]);
	assign pop_addr = pop_word[OP_W+ADDR_W-1:OP_W];

	pgbc_back #(
		.ADDR_W (ADDR_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_op            (pop_op),
		.q_addr          (pop_addr),
		.q_pop           (q_pop),
		.fluid_threshold (fluid_thr_q),
		.init_busy       (init_busy),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_result        (result)
	);

	// Pack the result item
	assign m_tdata = {7'b0, result.sum, result.cls, result.count, result.z, result.y,
		result.x};

endmodule

`default_nettype wire

>>> dv/tb_particle_grid_binning_classifier_unit.sv
// Self-checking testbench for particle_grid_binning_classifier_unit: stream driver,
// result monitor, APB register setup and a cell-store predictor kept in step with it.
// Depends on rtl/pgbc_pkg.sv and rtl/particle_grid_binning_classifier_unit.sv.
`default_nettype none

module tb_particle_grid_binning_classifier_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pgbc_pkg::*;

	localparam int NUM_CELLS = 32768;
	localparam int HOLD_CYCLES = 300;
	localparam int SAT_INSERTS = 260;
	localparam logic [2:0] ADDR_GRID_SIZE = {REG_GRID_SIZE, 2'b00};
	localparam logic [2:0] ADDR_FLUID_THR = {REG_FLUID_THR, 2'b00};

	// One input item as the stream carries it
	typedef struct packed {
		cmd_t        cmd;
		logic [19:0] px;
		logic [19:0] py;
		logic [19:0] pz;
		kind_t       kind;
		logic [15:0] dens;
		logic [4:0]  qx;
		logic [4:0]  qy;
		logic [4:0]  qz;
	} particle_op_t;

	// One cell report as the result stream carries it
	typedef struct packed {
		logic [4:0]  x;
		logic [4:0]  y;
		logic [4:0]  z;
		logic [15:0] count;
		class_t      cls;
		logic [23:0] sum;
	} cell_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// pos_x, pos_y, pos_z, particle_kind, particle_density, query_x, query_y, query_z
	logic [95:0] s_tdata = '0;
	// command
	logic [1:0]  s_tuser = CMD_CLEAR;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// cell_x, cell_y, cell_z, particle_count, cell_class, density_total
	logic [63:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Predictor copy of configuration and cell store
	logic [5:0]  grid_cfg;
	logic [23:0] thr_cfg;
	logic [15:0] cell_count [0:NUM_CELLS-1];
	logic        cell_wall  [0:NUM_CELLS-1];
	logic        cell_other [0:NUM_CELLS-1];
	logic [23:0] cell_sum   [0:NUM_CELLS-1];

	particle_op_t pending_ops[$];
	cell_report_t expected_reports[$];
	logic [14:0]  hot_cells[$];
	particle_op_t driven_op;
	cell_report_t got_report;
	cell_report_t want_report;

	int ops_queued = 0;
	int ops_accepted = 0;
	int reports_checked = 0;
	int mismatch_count = 0;
	int inserts_seen = 0;
	int queries_seen = 0;
	int clears_seen = 0;
	int noops_seen = 0;
	int input_stall_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int rx_hold_left = 0;
	logic rx_hold_req = 1'b0;

	particle_grid_binning_classifier_unit #(.MAX_GRID(32)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Zero and out-of-range grid sizes fold back into 1..32
	function automatic int cells_per_axis();
		if (grid_cfg == 6'd0) return 1;
		if (grid_cfg > 6'd32) return 32;
		return int'(grid_cfg);
	endfunction

	// Scale a signed Q16 coordinate to a cell index, truncate and clamp
	function automatic logic [4:0] bin_axis(logic [19:0] raw, int g);
		longint prod;
		longint idx;
		prod = longint'($signed(raw)) * g;
		if (prod < 0) return 5'd0;
		idx = prod >>> 16;
		if (idx > g - 1) idx = g - 1;
		return 5'(idx);
	endfunction

	function automatic void wipe_grid();
		for (int i = 0; i < NUM_CELLS; i++) begin
			cell_count[i] = '0;
			cell_wall[i] = 1'b0;
			cell_other[i] = 1'b0;
			cell_sum[i] = '0;
		end
	endfunction

	function automatic class_t classify_cell(logic [14:0] a);
		if (cell_wall[a]) return CLASS_WALL;
		if (cell_other[a]) return CLASS_AIR;
		return (cell_sum[a] > thr_cfg) ? CLASS_FLUID : CLASS_AIR;
	endfunction

	// Apply one item to the cell store and return the report it causes
	function automatic cell_report_t bin_and_classify(particle_op_t op);
		cell_report_t rep;
		int g;
		logic [14:0] a;
		logic [24:0] s;
		rep = '0;
		g = cells_per_axis();
		case (op.cmd)
			CMD_CLEAR: begin
				wipe_grid();
				clears_seen++;
			end
			CMD_INSERT: begin
				rep.x = bin_axis(op.px, g);
				rep.y = bin_axis(op.py, g);
				rep.z = bin_axis(op.pz, g);
				a = {rep.x, rep.y, rep.z};
				if (cell_count[a] != COUNT_MAX) cell_count[a] = cell_count[a] + 16'd1;
				case (op.kind)
					KIND_FLUID: begin
						s = {1'b0, cell_sum[a]} + {9'd0, op.dens};
						cell_sum[a] = s[24] ? SUM_MAX : s[23:0];
					end
					KIND_WALL: cell_wall[a] = 1'b1;
					default: cell_other[a] = 1'b1;
				endcase
				rep.count = cell_count[a];
				rep.cls = classify_cell(a);
				rep.sum = cell_sum[a];
				inserts_seen++;
			end
			CMD_QUERY: begin
				rep.x = op.qx;
				rep.y = op.qy;
				rep.z = op.qz;
				a = {op.qx, op.qy, op.qz};
				if (op.qx < g && op.qy < g && op.qz < g) begin
					rep.count = cell_count[a];
					rep.cls = classify_cell(a);
					rep.sum = cell_sum[a];
				end
				queries_seen++;
			end
			default: noops_seen++;
		endcase
		return rep;
	endfunction

	function automatic logic [95:0] pack_op(particle_op_t op);
		return {3'b000, op.qz, op.qy, op.qx, op.dens, op.kind, op.pz, op.py, op.px};
	endfunction

	// Drive items from the pending queue; predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_reports.insert(expected_reports.size(), bin_and_classify(driven_op));
				ops_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					driven_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= pack_op(driven_op);
					s_tuser <= driven_op.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check each accepted result against the oldest expected report
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_report.x = m_tdata[4:0];
				got_report.y = m_tdata[9:5];
				got_report.z = m_tdata[14:10];
				got_report.count = m_tdata[30:15];
				got_report.cls = class_t'(m_tdata[32:31]);
				got_report.sum = m_tdata[56:33];
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected result x=%0d y=%0d z=%0d cnt=%0d cls=%0d sum=%0d",
						$time, got_report.x, got_report.y, got_report.z, got_report.count,
						got_report.cls, got_report.sum);
					mismatch_count++;
				end else begin
					want_report = expected_reports.pop_front();
					reports_checked++;
					if (got_report.x !== want_report.x || got_report.y !== want_report.y ||
						got_report.z !== want_report.z ||
						got_report.count !== want_report.count ||
						got_report.cls !== want_report.cls ||
						got_report.sum !== want_report.sum) begin
						$display("%0t: mismatch expected x=%0d y=%0d z=%0d cnt=%0d cls=%0d sum=%0d",
							$time, want_report.x, want_report.y, want_report.z,
							want_report.count, want_report.cls, want_report.sum);
						$display("%0t:          actual   x=%0d y=%0d z=%0d cnt=%0d cls=%0d sum=%0d",
							$time, got_report.x, got_report.y, got_report.z,
							got_report.count, got_report.cls, got_report.sum);
						mismatch_count++;
					end
				end
			end
			m_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Count down a long receiver hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold_left <= 0;
		end else begin
			if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
			else if (rx_hold_req) rx_hold_left <= HOLD_CYCLES;
			if (rx_hold_left != 0 && s_tvalid && !s_tready) input_stall_cycles++;
		end
	end

	// APB write, then read back and compare
	task automatic reg_access(input logic [2:0] addr, input logic [31:0] value);
		logic [31:0] stored;
		logic [31:0] rd_value;
		stored = (addr == ADDR_GRID_SIZE) ? (value & 32'h3F) : (value & 32'hFF_FFFF);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_GRID_SIZE) grid_cfg = stored[5:0];
		else thr_cfg = stored[23:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd_value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd_value !== stored) begin
			$display("%0t: register read at %0d expected %0h actual %0h",
				$time, addr, stored, rd_value);
			mismatch_count++;
		end
	endtask

	task automatic queue_op(input cmd_t cmd, input logic [19:0] px, input logic [19:0] py,
		input logic [19:0] pz, input kind_t kind, input logic [15:0] dens,
		input logic [4:0] qx, input logic [4:0] qy, input logic [4:0] qz);
		particle_op_t op;
		op = '{cmd, px, py, pz, kind, dens, qx, qy, qz};
		pending_ops.insert(pending_ops.size(), op);
		ops_queued++;
	endtask

	// Wait until every item is accepted and every report has arrived
	task automatic drain();
		while (ops_accepted != ops_queued || expected_reports.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [19:0] random_pos();
		logic [19:0] v;
		int pick;
		pick = $urandom_range(99);
		if (pick < 75) begin
			v = 20'($urandom_range(65536));
		end else if (pick < 87) begin
			v = 20'($urandom);
		end else begin
			case ($urandom_range(5))
				0: v = 20'h00000;
				1: v = 20'h0FFFF;
				2: v = 20'h10000;
				3: v = 20'h7FFFF;
				4: v = 20'h80000;
				default: v = 20'hFFFFF;
			endcase
		end
		return v;
	endfunction

	function automatic logic [15:0] random_density();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) return 16'h0000;
		if (pick < 20) return 16'hFFFF;
		if (pick < 60) return 16'($urandom_range(255));
		return 16'($urandom);
	endfunction

	function automatic kind_t random_kind();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60) return KIND_FLUID;
		if (pick < 75) return KIND_WALL;
		if (pick < 90) return KIND_OTHER;
		return KIND_SPARE;
	endfunction

	// Random inserts, queries and unused commands; half the queries revisit recent cells
	task automatic queue_random_ops(input int n);
		logic [19:0] px, py, pz;
		logic [14:0] a;
		int g;
		int pick;
		g = cells_per_axis();
		hot_cells.delete();
		for (int i = 0; i < n; i++) begin
			px = random_pos();
			py = random_pos();
			pz = random_pos();
			pick = $urandom_range(99);
			if (pick < 55) begin
				hot_cells.insert(hot_cells.size(),
					{bin_axis(px, g), bin_axis(py, g), bin_axis(pz, g)});
				if (hot_cells.size() > 48) void'(hot_cells.pop_front());
				queue_op(CMD_INSERT, px, py, pz, random_kind(), random_density(),
					5'($urandom), 5'($urandom), 5'($urandom));
			end else if (pick < 93) begin
				pick = $urandom_range(99);
				if (pick < 50 && hot_cells.size() != 0)
					a = hot_cells[$urandom_range(hot_cells.size() - 1)];
				else if (pick < 80)
					a = {5'($urandom_range(g - 1)), 5'($urandom_range(g - 1)),
						5'($urandom_range(g - 1))};
				else
					a = 15'($urandom);
				queue_op(CMD_QUERY, px, py, pz, random_kind(), random_density(),
					a[14:10], a[9:5], a[4:0]);
			end else begin
				queue_op(CMD_NONE, px, py, pz, random_kind(), random_density(),
					5'($urandom), 5'($urandom), 5'($urandom));
			end
		end
	endtask

	// Configure, clear the grid, then run random items under one idling mode
	task automatic run_phase(input logic [31:0] gsize, input logic [31:0] thr,
		input int sidle, input int ridle, input int n, input bit hold_rx);
		reg_access(ADDR_GRID_SIZE, gsize);
		reg_access(ADDR_FLUID_THR, thr);
		send_idle_pct <= sidle;
		recv_idle_pct <= ridle;
		queue_op(CMD_CLEAR, '0, '0, '0, KIND_FLUID, '0, '0, '0, '0);
		drain();
		queue_random_ops(n);
		if (hold_rx) begin
			repeat (10) @(posedge clk);
			rx_hold_req <= 1'b1;
			while (rx_hold_left == 0) @(posedge clk);
			rx_hold_req <= 1'b0;
		end
		drain();
	endtask

	initial begin
		#40_000_000;
		$display("FAIL particle_grid_binning_classifier_unit");
		$finish;
	end

	initial begin
		grid_cfg = GRID_SIZE_RST;
		thr_cfg = FLUID_THR_RST;
		wipe_grid();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: corners of the position range, every kind and command, edges of
		// the threshold compare, queries past the grid edge
		reg_access(ADDR_GRID_SIZE, 32'd4);
		reg_access(ADDR_FLUID_THR, 32'd51);
		send_idle_pct <= 33;
		recv_idle_pct <= 49;
		queue_op(CMD_QUERY, '0, '0, '0, KIND_FLUID, '0, 5'd0, 5'd0, 5'd0);
		queue_op(CMD_INSERT, 20'h0, 20'h0, 20'h0, KIND_FLUID, 16'h0, '0, '0, '0);
		queue_op(CMD_INSERT, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, KIND_FLUID, 16'hFFFF,
			'0, '0, '0);
		queue_op(CMD_INSERT, 20'h80000, 20'h80000, 20'h80000, KIND_WALL, 16'hFFFF,
			'0, '0, '0);
		queue_op(CMD_INSERT, 20'h0FFFF, 20'h10000, 20'hFFFFF, KIND_OTHER, 16'h1234,
			'0, '0, '0);
		queue_op(CMD_INSERT, 20'h04000, 20'h04000, 20'h04000, KIND_SPARE, 16'h00FF,
			'0, '0, '0);
		queue_op(CMD_INSERT, 20'h04000, 20'h04000, 20'h04000, KIND_FLUID, 16'hFFFF,
			'0, '0, '0);
		queue_op(CMD_INSERT, 20'h08000, 20'h08000, 20'h08000, KIND_FLUID, 16'd51,
			'0, '0, '0);
		queue_op(CMD_INSERT, 20'h08000, 20'h08000, 20'h08000, KIND_FLUID, 16'd1,
			'0, '0, '0);
		queue_op(CMD_QUERY, '0, '0, '0, KIND_FLUID, '0, 5'd3, 5'd3, 5'd3);
		queue_op(CMD_QUERY, '0, '0, '0, KIND_FLUID, '0, 5'd0, 5'd0, 5'd0);
		queue_op(CMD_QUERY, '0, '0, '0, KIND_FLUID, '0, 5'd1, 5'd1, 5'd1);
		queue_op(CMD_QUERY, '0, '0, '0, KIND_FLUID, '0, 5'd2, 5'd2, 5'd2);
		queue_op(CMD_QUERY, '0, '0, '0, KIND_FLUID, '0, 5'd3, 5'd3, 5'd0);
		queue_op(CMD_QUERY, '1, '1, '1, KIND_SPARE, '1, 5'd4, 5'd0, 5'd0);
		queue_op(CMD_QUERY, '0, '0, '0, KIND_FLUID, '0, 5'd0, 5'd0, 5'd4);
		queue_op(CMD_QUERY, '0, '0, '0, KIND_FLUID, '0, 5'd31, 5'd31, 5'd31);
		queue_op(CMD_NONE, '1, '1, '1, KIND_SPARE, '1, '1, '1, '1);
		queue_op(CMD_NONE, '0, '0, '0, KIND_FLUID, '0, '0, '0, '0);
		queue_op(CMD_CLEAR, '1, '1, '1, KIND_SPARE, '1, '1, '1, '1);
		queue_op(CMD_QUERY, '0, '0, '0, KIND_FLUID, '0, 5'd3, 5'd3, 5'd3);
		queue_op(CMD_QUERY, '0, '0, '0, KIND_FLUID, '0, 5'd0, 5'd0, 5'd0);
		drain();

		// Random phases: receiver-heavy idling, then sender-heavy, then none
		run_phase(32'd0, 32'd0, 33, 49, 75, 1'b0);
		run_phase(32'd63, 32'hFF_FFFF, 33, 49, 75, 1'b0);
		run_phase(32'd1, 32'($urandom_range(24'h3FFFF)), 49, 33, 75, 1'b0);
		run_phase(32'd32, 32'd51, 49, 33, 75, 1'b1);
		run_phase(32'd7, 32'h300, 0, 0, 75, 1'b0);
		run_phase(32'($urandom_range(2, 31)), 32'($urandom_range(24'hFFFF)), 0, 0, 75,
			1'b0);

		// Pile fluid into one cell until the density sum saturates
		reg_access(ADDR_GRID_SIZE, 32'd32);
		reg_access(ADDR_FLUID_THR, 32'hFF_FFFE);
		queue_op(CMD_CLEAR, '0, '0, '0, KIND_FLUID, '0, '0, '0, '0);
		for (int i = 0; i < SAT_INSERTS; i++)
			queue_op(CMD_INSERT, 20'h10000, 20'h00000, 20'h08000, KIND_FLUID, 16'hFFFF,
				'0, '0, '0);
		queue_op(CMD_QUERY, '0, '0, '0, KIND_FLUID, '0, 5'd31, 5'd0, 5'd16);
		drain();

		$display("Covered %0d inserts, %0d queries, %0d clears, %0d unused commands;",
			inserts_seen, queries_seen, clears_seen, noops_seen);
		$display("%0d results checked, grid sizes 0..63, %0d input stall cycles under hold",
			reports_checked, input_stall_cycles);
		if (mismatch_count == 0) begin
			$display("PASS particle_grid_binning_classifier_unit");
		end else begin
			$display("FAIL particle_grid_binning_classifier_unit");
		end
		$finish;
	end

endmodule

`default_nettype wire
